// ===== rtl/core/rfid_frame_receiver_assert.svh =====
// ----------------------------------------------------------------------------
// RFID frame receiver assertion macros
// Shared concurrent assertion forms for the receiver checkers.
// ----------------------------------------------------------------------------
`ifndef RFID_FRAME_RECEIVER_ASSERT_SVH
`define RFID_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication
`define RFR_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// next-cycle implication
`define RFR_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/rfr_pkg.sv =====
// ----------------------------------------------------------------------------
// RFID frame receiver package
// Codes, widths and the attempt state type shared by the receiver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rfr_pkg;

    localparam int CFG_W = 16;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_BAD_END = 2'd2;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HUNT  = 2'd1;
    localparam logic [1:0] PH_FRAME = 2'd2;
    localparam logic [1:0] PH_DRAIN = 2'd3;

    localparam logic [0:0] REG_TIMEOUT_LIMIT = 1'd0;
    localparam logic [0:0] REG_QUIET_LIMIT   = 1'd1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd80;
    localparam logic [15:0] QUIET_RESET   = 16'd20;

    localparam logic [7:0] START_MARK   = 8'h02;
    localparam logic [7:0] END_MARK     = 8'h03;
    localparam logic [3:0] TAG_FIRST    = 4'd3;
    localparam logic [3:0] TAG_LAST     = 4'd10;
    localparam logic [3:0] END_POSITION = 4'd13;

    typedef struct packed {
        logic [1:0]  phase;
        logic [3:0]  pos;
        logic [15:0] elapsed;
        logic [15:0] quiet;
        logic [63:0] tag;
        logic [1:0]  pending;
    } attempt_t;

    localparam attempt_t ATTEMPT_CLEAR = '{
        phase:   PH_IDLE,
        pos:     4'd0,
        elapsed: 16'd0,
        quiet:   16'd0,
        tag:     64'd0,
        pending: ST_OK
    };

    typedef struct packed {
        logic        emit;
        logic [1:0]  status;
        logic [63:0] tag_chars;
    } result_t;

endpackage

// ===== rtl/core/rfid_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// RFID frame receiver
// Parses a 14-byte serial tag frame during a read attempt, with timeout.
// ----------------------------------------------------------------------------
// Items (start, received byte, millisecond tick) are accepted one per clock
// while s_tready is high. Each item is captured in an input register and
// processed combinationally against the attempt state, and any result lands
// in a one-entry result register, so a result passes through both registers.
// s_tready drops only while an item waits in the input register and the
// result register holds an item the master side has not taken.
`timescale 1ns / 1ps

module rfid_frame_receiver
    import rfr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [0:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] rx_byte
    input  logic [7:0]       s_tuser,   // [1:0] opcode, [7:2] zero
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [63:0]      m_tdata,   // [63:0] tag_chars
    output logic [7:0]       m_tuser    // [1:0] status, [7:2] zero
);

    logic [CFG_W-1:0] timeout_reg;
    logic [CFG_W-1:0] quiet_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    logic [1:0]       opcode_reg;
    logic [7:0]       byte_reg;
    attempt_t         state_reg;
    attempt_t         state_next;
    result_t          res;
    logic             room;
    logic             advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            quiet_reg   <= QUIET_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT_LIMIT: timeout_reg <= cfg_data;
                REG_QUIET_LIMIT:   quiet_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign advance       = in_valid_reg && room;
    assign s_tready      = !in_valid_reg || room;
    assign in_valid_next = (s_tvalid && s_tready) ? 1'b1 : (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= ATTEMPT_CLEAR;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            opcode_reg <= s_tuser[1:0];
            byte_reg   <= s_tdata;
        end
    end

    rfr_step u_step (
        .cur           (state_reg),
        .opcode        (opcode_reg),
        .rx_byte       (byte_reg),
        .timeout_limit (timeout_reg),
        .quiet_limit   (quiet_reg),
        .nxt           (state_next),
        .res           (res)
    );

    rfr_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res      (res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== rtl/core/rfr_step.sv =====
// ----------------------------------------------------------------------------
// RFID frame receiver step logic
// Next attempt state and optional result for one registered item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfr_step
    import rfr_pkg::*;
(
    input  attempt_t          cur,
    input  logic [1:0]        opcode,
    input  logic [7:0]        rx_byte,
    input  logic [CFG_W-1:0]  timeout_limit,
    input  logic [CFG_W-1:0]  quiet_limit,
    output attempt_t          nxt,
    output result_t           res
);

    logic [15:0] elapsed_inc;
    logic [15:0] quiet_inc;

    assign elapsed_inc = (cur.elapsed == 16'hFFFF) ? cur.elapsed : cur.elapsed + 16'd1;
    assign quiet_inc   = (cur.quiet == 16'hFFFF) ? cur.quiet : cur.quiet + 16'd1;

    always_comb
    begin
        nxt           = cur;
        res.emit      = 1'b0;
        res.status    = ST_OK;
        res.tag_chars = 64'd0;
        case (opcode)
            OP_START:
            begin
                nxt = ATTEMPT_CLEAR;
                if (timeout_limit == '0)
                begin
                    res.emit   = 1'b1;
                    res.status = ST_TIMEOUT;
                end
                else
                begin
                    nxt.phase = PH_HUNT;
                end
            end
            OP_BYTE:
            begin
                case (cur.phase)
                    PH_HUNT:
                    begin
                        if (rx_byte == START_MARK)
                        begin
                            nxt.phase = PH_FRAME;
                            nxt.pos   = 4'd1;
                        end
                    end
                    PH_FRAME:
                    begin
                        if (cur.pos inside {[TAG_FIRST:TAG_LAST]})
                        begin
                            nxt.tag = {cur.tag[55:0], rx_byte};
                        end
                        if (cur.pos >= END_POSITION)
                        begin
                            nxt.pending = (rx_byte == END_MARK) ? ST_OK : ST_BAD_END;
                            nxt.phase   = PH_DRAIN;
                            nxt.quiet   = 16'd0;
                            if (quiet_limit == '0)
                            begin
                                res.emit   = 1'b1;
                                res.status = nxt.pending;
                            end
                        end
                        else
                        begin
                            nxt.pos = cur.pos + 4'd1;
                        end
                    end
                    PH_DRAIN:
                    begin
                        nxt.quiet = 16'd0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_TICK:
            begin
                case (cur.phase)
                    PH_HUNT, PH_FRAME:
                    begin
                        nxt.elapsed = elapsed_inc;
                        if (elapsed_inc >= timeout_limit)
                        begin
                            res.emit   = 1'b1;
                            res.status = ST_TIMEOUT;
                        end
                    end
                    PH_DRAIN:
                    begin
                        nxt.quiet = quiet_inc;
                        if (quiet_inc >= quiet_limit)
                        begin
                            res.emit   = 1'b1;
                            res.status = cur.pending;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        if (res.emit)
        begin
            res.tag_chars = (res.status == ST_OK) ? nxt.tag : 64'd0;
            nxt           = ATTEMPT_CLEAR;
        end
    end

endmodule

// ===== rtl/core/rfr_out_reg.sv =====
// ----------------------------------------------------------------------------
// RFID frame receiver result register
// Holds one result item until the master side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rfr_out_reg
    import rfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  result_t     res,
    output logic        room,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,
    output logic [7:0]  m_tuser
);

    logic        valid_reg;
    logic        valid_next;
    logic [1:0]  status_reg;
    logic [63:0] tag_reg;

    assign room       = !valid_reg || m_tready;
    assign valid_next = (load && res.emit) ? 1'b1 : (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res.emit)
        begin
            status_reg <= res.status;
            tag_reg    <= res.tag_chars;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = tag_reg;
    assign m_tuser  = {6'd0, status_reg};

endmodule

// ===== rtl/core/rfr_checker.sv =====
// ----------------------------------------------------------------------------
// RFID frame receiver checker
// Port-level assertions, bound to the receiver top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rfid_frame_receiver_assert.svh"

module rfr_checker
    import rfr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [7:0]  m_tuser
);

    `RFR_ASSERT_NEXT(a_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `RFR_ASSERT_IMPLY(a_tag_zero, clk, rst_n, m_tvalid && (m_tuser[1:0] != ST_OK),
                      m_tdata == 64'd0)
    `RFR_ASSERT_IMPLY(a_status_code, clk, rst_n, m_tvalid,
                      (m_tuser[1:0] == ST_OK) || (m_tuser[1:0] == ST_TIMEOUT) ||
                      (m_tuser[1:0] == ST_BAD_END))
    `RFR_ASSERT_IMPLY(a_ready_flow, clk, rst_n, m_tready, s_tready)

endmodule

bind rfid_frame_receiver rfr_checker u_rfr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
